@@ sv/sfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for sequenced fragment reassembly
// Holds widths, verdict codes, configuration indexes and the records that
// travel between the top level and the header decision logic.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Reassembly buffer size in bytes
  localparam int unsigned BUFFER_BYTES = 16384;

  // Field widths
  localparam int unsigned SEQ_W     = 31;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned FSIZE_W   = 14;
  localparam int unsigned MAXMSG_W  = 16;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned OUT_LEN_W = 15;

  // Assembled byte count and the width of sums built on it
  localparam int unsigned LEN_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned SUM_W = ((LEN_W > FIELD_W) ? LEN_W : FIELD_W) + 1;

  // Bit of the length field that marks the last fragment in extended mode
  localparam int unsigned LAST_FLAG_BIT = 14;

  // Stream widths (whole bytes)
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - SEQ_W - 3 * OUT_LEN_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_EXT_LAST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTH_CHECK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAG_SIZE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG    = 2'd3;

  localparam logic                RST_EXT_LAST   = 1'b0;
  localparam logic                RST_AUTH_CHECK = 1'b1;
  localparam logic [FSIZE_W-1:0]  RST_FRAG_SIZE  = 14'd1300;
  localparam logic [MAXMSG_W-1:0] RST_MAX_MSG    = 16'd16384;

  // Verdict codes
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_DELIVER = 3'd0,
    VERDICT_STORED  = 3'd1,
    VERDICT_AUTH    = 3'd2,
    VERDICT_STALE   = 3'd3,
    VERDICT_GAP     = 3'd4,
    VERDICT_BADLEN  = 3'd5,
    VERDICT_LARGE   = 3'd6
  } verdict_e;

  // One header item
  typedef struct packed {
    logic [SEQ_W-1:0]          sequence_number;
    logic                      is_fragment;
    logic signed [FIELD_W-1:0] frag_start;
    logic signed [FIELD_W-1:0] frag_length_raw;
    logic [FIELD_W-1:0]        payload_bytes_left;
    logic                      auth_ok;
  } item_t;

  // Configuration registers
  typedef struct packed {
    logic                extended_last_flag;
    logic                auth_check_enabled;
    logic [FSIZE_W-1:0]  full_frag_len;
    logic [MAXMSG_W-1:0] max_message_bytes;
  } cfg_t;

  // Channel state
  typedef struct packed {
    logic [SEQ_W-1:0] last_accepted_sequence;
    logic [SEQ_W-1:0] assembling_sequence;
    logic [LEN_W-1:0] assembled_bytes;
  } state_t;

  // One result item
  typedef struct packed {
    verdict_e             verdict;
    logic [SEQ_W-1:0]     skipped_count;
    logic [OUT_LEN_W-1:0] copy_offset;
    logic [OUT_LEN_W-1:0] copy_length;
    logic [OUT_LEN_W-1:0] message_length;
  } result_t;

endpackage

@@ sv/sfr_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_check: header decision logic
// Judges one header against the channel state and configuration, and gives
// the result item together with the state that follows it.
// ----------------------------------------------------------------------------
module sfr_check (
  input  sfr_pkg::item_t   item_i,
  input  sfr_pkg::cfg_t    cfg_i,
  input  sfr_pkg::state_t  state_i,
  output sfr_pkg::result_t result_o,
  output sfr_pkg::state_t  state_o
);

  logic                         auth_fail;
  logic                         stale;
  logic [sfr_pkg::SEQ_W-1:0]    skipped;
  logic [sfr_pkg::FIELD_W-1:0]  len;
  logic                         is_last;
  logic                         new_asm;
  logic [sfr_pkg::LEN_W-1:0]    base;
  logic [sfr_pkg::SUM_W-1:0]    base_ext;
  logic [sfr_pkg::SUM_W-1:0]    len_ext;
  logic [sfr_pkg::SUM_W-1:0]    total;
  logic                         gap;
  logic                         bad_len;
  logic                         too_large;

  // Sequence checks
  assign auth_fail = item_i.auth_ok == 1'b0 && cfg_i.auth_check_enabled;
  assign stale     = item_i.sequence_number <= state_i.last_accepted_sequence;
  assign skipped   = item_i.sequence_number - state_i.last_accepted_sequence
                     - sfr_pkg::SEQ_W'(1);

  // Extract the length and the last-fragment mark
  always_comb begin
    len = item_i.frag_length_raw;
    if (cfg_i.extended_last_flag) begin
      len[sfr_pkg::LAST_FLAG_BIT] = 1'b0;
      is_last = item_i.frag_length_raw[sfr_pkg::LAST_FLAG_BIT];
    end else begin
      is_last = len != sfr_pkg::FIELD_W'(cfg_i.full_frag_len);
    end
  end

  // Restart assembly on a new fragment sequence
  assign new_asm  = item_i.sequence_number != state_i.assembling_sequence;
  assign base     = new_asm ? '0 : state_i.assembled_bytes;
  assign base_ext = sfr_pkg::SUM_W'(base);
  assign len_ext  = sfr_pkg::SUM_W'(len[sfr_pkg::FIELD_W-2:0]);
  assign total    = base_ext + len_ext;

  // Offset, length and size checks
  assign gap = item_i.frag_start[sfr_pkg::FIELD_W-1]
               || sfr_pkg::SUM_W'(item_i.frag_start[sfr_pkg::FIELD_W-2:0]) != base_ext;
  assign bad_len = len[sfr_pkg::FIELD_W-1]
                   || len > item_i.payload_bytes_left
                   || total > sfr_pkg::SUM_W'(sfr_pkg::BUFFER_BYTES);
  assign too_large = total > sfr_pkg::SUM_W'(cfg_i.max_message_bytes);

  // Decide the verdict and the next state
  always_comb begin
    result_o.verdict        = sfr_pkg::VERDICT_AUTH;
    result_o.skipped_count  = '0;
    result_o.copy_offset    = '0;
    result_o.copy_length    = '0;
    result_o.message_length = '0;
    state_o                 = state_i;
    priority if (auth_fail) begin
      result_o.verdict = sfr_pkg::VERDICT_AUTH;
    end else if (stale) begin
      result_o.verdict = sfr_pkg::VERDICT_STALE;
    end else if (!item_i.is_fragment) begin
      result_o.verdict               = sfr_pkg::VERDICT_DELIVER;
      result_o.skipped_count         = skipped;
      state_o.last_accepted_sequence = item_i.sequence_number;
    end else begin
      result_o.skipped_count      = skipped;
      state_o.assembling_sequence = item_i.sequence_number;
      state_o.assembled_bytes     = base;
      priority if (gap) begin
        result_o.verdict = sfr_pkg::VERDICT_GAP;
      end else if (bad_len) begin
        result_o.verdict = sfr_pkg::VERDICT_BADLEN;
      end else begin
        result_o.copy_offset    = sfr_pkg::OUT_LEN_W'(base);
        result_o.copy_length    = sfr_pkg::OUT_LEN_W'(len_ext);
        state_o.assembled_bytes = sfr_pkg::LEN_W'(total);
        priority if (!is_last) begin
          result_o.verdict = sfr_pkg::VERDICT_STORED;
        end else if (too_large) begin
          result_o.verdict = sfr_pkg::VERDICT_LARGE;
        end else begin
          result_o.verdict               = sfr_pkg::VERDICT_DELIVER;
          result_o.message_length        = sfr_pkg::OUT_LEN_W'(total);
          state_o.assembled_bytes        = '0;
          state_o.last_accepted_sequence = item_i.sequence_number;
        end
      end
    end
  end

endmodule

@@ sv/sequenced_fragment_reassembly.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequenced_fragment_reassembly: datagram sequence and fragment check
// Receive-side header check: rejects failed authentication and stale
// sequences, counts skipped sequences and tracks in-order fragment assembly.
//
// Channel  Direction  Transfer when           Carries
// s_axis   in         tvalid & tready         one datagram header
// m_axis   out        tvalid & tready         one verdict per header
// cfg      in         cfg_valid & cfg_ready   register index and value
//
// One header per cycle sustained while m_axis takes results; a header passes
// through the input register, then the result register, before it transfers.
// The decision and the state update happen together as a header moves from
// the input register to the result register, so back-to-back headers see
// each other's state. Reset clears the channel state and loads the register
// defaults. A stall on m_axis holds the result register; the input register
// still takes one header, then s_axis_tready drops until the result leaves.
// ----------------------------------------------------------------------------
module sequenced_fragment_reassembly (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sequence_number, frag_start, frag_length_raw, payload_bytes_left, auth_ok
  input  logic [sfr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // is_fragment
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // skipped_count, copy_offset, copy_length, message_length, zero pad
  output logic [sfr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // verdict
  output logic [sfr_pkg::VERDICT_W-1:0]      m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  sfr_pkg::item_t   in_d;
  sfr_pkg::item_t   in_q;
  logic             in_valid_q;
  sfr_pkg::result_t out_q;
  logic             out_valid_q;
  sfr_pkg::state_t  state_q;
  sfr_pkg::state_t  state_d;
  sfr_pkg::cfg_t    cfg_q;
  sfr_pkg::result_t result;
  logic             advance;
  logic             in_take;

  // Handshakes
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Unpack the header
  always_comb begin
    in_d.sequence_number    = s_axis_tdata[30:0];
    in_d.frag_start         = s_axis_tdata[46:31];
    in_d.frag_length_raw    = s_axis_tdata[62:47];
    in_d.payload_bytes_left = s_axis_tdata[78:63];
    in_d.auth_ok            = s_axis_tdata[79];
    in_d.is_fragment        = s_axis_tuser;
  end

  // Hold the accepted header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_d;
    end
  end

  // Decide the header
  sfr_check u_check (
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .result_o (result),
    .state_o  (state_d)
  );

  // Advance the channel state with each decided header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  // Drive the result stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.verdict;
  assign m_axis_tdata  = {{sfr_pkg::OUT_PAD_W{1'b0}}, out_q.message_length,
                          out_q.copy_length, out_q.copy_offset, out_q.skipped_count};

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.extended_last_flag <= sfr_pkg::RST_EXT_LAST;
      cfg_q.auth_check_enabled <= sfr_pkg::RST_AUTH_CHECK;
      cfg_q.full_frag_len      <= sfr_pkg::RST_FRAG_SIZE;
      cfg_q.max_message_bytes  <= sfr_pkg::RST_MAX_MSG;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        sfr_pkg::CFG_EXT_LAST: begin
          cfg_q.extended_last_flag <= cfg_data_i[0];
        end
        sfr_pkg::CFG_AUTH_CHECK: begin
          cfg_q.auth_check_enabled <= cfg_data_i[0];
        end
        sfr_pkg::CFG_FRAG_SIZE: begin
          cfg_q.full_frag_len <= cfg_data_i[sfr_pkg::FSIZE_W-1:0];
        end
        sfr_pkg::CFG_MAX_MSG: begin
          cfg_q.max_message_bytes <= cfg_data_i[sfr_pkg::MAXMSG_W-1:0];
        end
      endcase
    end
  end

endmodule
